// File: sv/dll_pkg.sv
package dll_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam ptr_t NIL = PTR_W'(CAPACITY);

    localparam logic [4:0] CMD_CLEAR        = 5'd0;
    localparam logic [4:0] CMD_INS_FIRST    = 5'd1;
    localparam logic [4:0] CMD_INS_LAST     = 5'd2;
    localparam logic [4:0] CMD_CUR_FIRST    = 5'd3;
    localparam logic [4:0] CMD_CUR_LAST     = 5'd4;
    localparam logic [4:0] CMD_RD_FIRST     = 5'd5;
    localparam logic [4:0] CMD_RD_LAST      = 5'd6;
    localparam logic [4:0] CMD_DEL_FIRST    = 5'd7;
    localparam logic [4:0] CMD_DEL_LAST     = 5'd8;
    localparam logic [4:0] CMD_DEL_AFTER    = 5'd9;
    localparam logic [4:0] CMD_DEL_BEFORE   = 5'd10;
    localparam logic [4:0] CMD_INS_AFTER    = 5'd11;
    localparam logic [4:0] CMD_INS_BEFORE   = 5'd12;
    localparam logic [4:0] CMD_RD_ACTIVE    = 5'd13;
    localparam logic [4:0] CMD_WRITE_ACTIVE = 5'd14;
    localparam logic [4:0] CMD_NEXT         = 5'd15;
    localparam logic [4:0] CMD_PREV         = 5'd16;
    localparam logic [4:0] CMD_QUERY        = 5'd17;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_NOACT = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    typedef struct packed {
        logic  val_we;
        idx_t  val_waddr;
        data_t val_wdata;
        idx_t  val_raddr;
        logic  nxt_we;
        idx_t  nxt_waddr;
        ptr_t  nxt_wdata;
        idx_t  nxt_raddr;
        logic  prv_we;
        idx_t  prv_waddr;
        ptr_t  prv_wdata;
        idx_t  prv_raddr;
        logic  fre_we;
        idx_t  fre_waddr;
        idx_t  fre_wdata;
        idx_t  fre_raddr;
    } dll_mem_req_t;

    typedef struct packed {
        data_t val;
        ptr_t  nxt;
        ptr_t  prv;
        idx_t  fre;
    } dll_mem_rsp_t;

endpackage

// File: sv/dll_ram.sv
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/dll_ctrl.sv
module dll_ctrl
    import dll_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [4:0]          command,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  read_value,
    output logic [1:0]          status,
    output logic                cursor_active,
    output dll_mem_req_t        mem_req,
    input  dll_mem_rsp_t        mem_rsp
);

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_FIND, S_UNLINK, S_LINK} state_t;

    state_t     state_reg, state_next;
    ptr_t       head_reg, head_next, tail_reg, tail_next, cur_reg, cur_next;
    ptr_t       fc_reg, fc_next, bump_reg, bump_next;
    ptr_t       n_reg, n_next, a_reg, a_next, b_reg, b_next;
    logic [4:0] cmd_reg, cmd_next;
    data_t      val_reg, val_next;
    logic       out_valid_reg, out_valid_next;
    data_t      rdv_reg, rdv_next;
    logic [1:0] status_reg, status_next;
    logic       act_reg, act_next;

    logic       accept, done, full;
    data_t      rd;
    logic [1:0] st;
    ptr_t       fc_dec, n_sel, a_sel, b_sel, find_n;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign fc_dec   = fc_reg - PTR_W'(1);
    assign full     = (fc_reg == '0) && (bump_reg == NIL);
    assign n_sel    = (fc_reg != '0) ? {1'b0, mem_rsp.fre} : bump_reg;
    assign find_n   = (cmd_reg == CMD_DEL_AFTER) ? mem_rsp.nxt : mem_rsp.prv;

    always_comb
    begin
        unique case (cmd_reg)
            CMD_INS_FIRST:
            begin
                a_sel = NIL;
                b_sel = head_reg;
            end
            CMD_INS_LAST:
            begin
                a_sel = tail_reg;
                b_sel = NIL;
            end
            CMD_INS_AFTER:
            begin
                a_sel = cur_reg;
                b_sel = mem_rsp.nxt;
            end
            default:
            begin
                a_sel = mem_rsp.prv;
                b_sel = cur_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_req    = '0;
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        fc_next    = fc_reg;
        bump_next  = bump_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        done       = 1'b0;
        rd         = '0;
        st         = STAT_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    val_next = value;
                    mem_req.fre_raddr = fc_dec[IDX_W-1:0];
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            head_next = NIL;
                            tail_next = NIL;
                            cur_next  = NIL;
                            fc_next   = '0;
                            bump_next = '0;
                            done      = 1'b1;
                        end
                        CMD_INS_FIRST, CMD_INS_LAST:
                        begin
                            state_next = S_LOOK;
                        end
                        CMD_INS_AFTER, CMD_INS_BEFORE:
                        begin
                            mem_req.nxt_raddr = cur_reg[IDX_W-1:0];
                            mem_req.prv_raddr = cur_reg[IDX_W-1:0];
                            if (cur_reg == NIL)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        CMD_CUR_FIRST:
                        begin
                            cur_next = head_reg;
                            done     = 1'b1;
                        end
                        CMD_CUR_LAST:
                        begin
                            cur_next = tail_reg;
                            done     = 1'b1;
                        end
                        CMD_RD_FIRST, CMD_RD_LAST:
                        begin
                            mem_req.val_raddr = (command == CMD_RD_FIRST) ?
                                head_reg[IDX_W-1:0] : tail_reg[IDX_W-1:0];
                            if (head_reg == NIL)
                            begin
                                st   = STAT_EMPTY;
                                done = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        CMD_RD_ACTIVE:
                        begin
                            mem_req.val_raddr = cur_reg[IDX_W-1:0];
                            if (cur_reg == NIL)
                            begin
                                st   = STAT_NOACT;
                                done = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                        CMD_DEL_FIRST, CMD_DEL_LAST:
                        begin
                            n_next = (command == CMD_DEL_FIRST) ? head_reg : tail_reg;
                            mem_req.nxt_raddr = n_next[IDX_W-1:0];
                            mem_req.prv_raddr = n_next[IDX_W-1:0];
                            if (head_reg == NIL)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                state_next = S_UNLINK;
                            end
                        end
                        CMD_DEL_AFTER, CMD_DEL_BEFORE, CMD_NEXT, CMD_PREV:
                        begin
                            mem_req.nxt_raddr = cur_reg[IDX_W-1:0];
                            mem_req.prv_raddr = cur_reg[IDX_W-1:0];
                            if (cur_reg == NIL)
                            begin
                                done = 1'b1;
                            end
                            else if (command == CMD_NEXT || command == CMD_PREV)
                            begin
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        CMD_WRITE_ACTIVE:
                        begin
                            mem_req.val_we    = (cur_reg != NIL);
                            mem_req.val_waddr = cur_reg[IDX_W-1:0];
                            mem_req.val_wdata = value;
                            done              = 1'b1;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                unique case (cmd_reg)
                    CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AFTER, CMD_INS_BEFORE:
                    begin
                        if (full)
                        begin
                            st   = STAT_FULL;
                            done = 1'b1;
                        end
                        else
                        begin
                            n_next = n_sel;
                            a_next = a_sel;
                            b_next = b_sel;
                            mem_req.val_we    = 1'b1;
                            mem_req.val_waddr = n_sel[IDX_W-1:0];
                            mem_req.val_wdata = val_reg;
                            mem_req.nxt_we    = 1'b1;
                            mem_req.nxt_waddr = n_sel[IDX_W-1:0];
                            mem_req.nxt_wdata = b_sel;
                            mem_req.prv_we    = 1'b1;
                            mem_req.prv_waddr = n_sel[IDX_W-1:0];
                            mem_req.prv_wdata = a_sel;
                            if (fc_reg != '0)
                            begin
                                fc_next = fc_dec;
                            end
                            else
                            begin
                                bump_next = bump_reg + PTR_W'(1);
                            end
                            state_next = S_LINK;
                        end
                    end
                    CMD_NEXT:
                    begin
                        cur_next = mem_rsp.nxt;
                        done     = 1'b1;
                    end
                    CMD_PREV:
                    begin
                        cur_next = mem_rsp.prv;
                        done     = 1'b1;
                    end
                    default:
                    begin
                        rd   = mem_rsp.val;
                        done = 1'b1;
                    end
                endcase
            end
            S_LINK:
            begin
                mem_req.nxt_we    = (a_reg != NIL);
                mem_req.nxt_waddr = a_reg[IDX_W-1:0];
                mem_req.nxt_wdata = n_reg;
                mem_req.prv_we    = (b_reg != NIL);
                mem_req.prv_waddr = b_reg[IDX_W-1:0];
                mem_req.prv_wdata = n_reg;
                if (a_reg == NIL)
                begin
                    head_next = n_reg;
                end
                if (b_reg == NIL)
                begin
                    tail_next = n_reg;
                end
                done = 1'b1;
            end
            S_FIND:
            begin
                n_next = find_n;
                mem_req.nxt_raddr = find_n[IDX_W-1:0];
                mem_req.prv_raddr = find_n[IDX_W-1:0];
                if (find_n == NIL)
                begin
                    done = 1'b1;
                end
                else
                begin
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                mem_req.nxt_we    = (mem_rsp.prv != NIL);
                mem_req.nxt_waddr = mem_rsp.prv[IDX_W-1:0];
                mem_req.nxt_wdata = mem_rsp.nxt;
                mem_req.prv_we    = (mem_rsp.nxt != NIL);
                mem_req.prv_waddr = mem_rsp.nxt[IDX_W-1:0];
                mem_req.prv_wdata = mem_rsp.prv;
                if (mem_rsp.prv == NIL)
                begin
                    head_next = mem_rsp.nxt;
                end
                if (mem_rsp.nxt == NIL)
                begin
                    tail_next = mem_rsp.prv;
                end
                if (cur_reg == n_reg)
                begin
                    cur_next = NIL;
                end
                mem_req.fre_we    = (fc_reg < NIL);
                mem_req.fre_waddr = fc_reg[IDX_W-1:0];
                mem_req.fre_wdata = n_reg[IDX_W-1:0];
                if (fc_reg < NIL)
                begin
                    fc_next = fc_reg + PTR_W'(1);
                end
                done = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (done)
        begin
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        rdv_next       = rdv_reg;
        status_next    = status_reg;
        act_next       = act_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            rdv_next       = rd;
            status_next    = st;
            act_next       = (cur_next != NIL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cur_reg       <= NIL;
            fc_reg        <= '0;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
            rdv_reg       <= '0;
            status_reg    <= STAT_OK;
            act_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cur_reg       <= cur_next;
            fc_reg        <= fc_next;
            bump_reg      <= bump_next;
            out_valid_reg <= out_valid_next;
            rdv_reg       <= rdv_next;
            status_reg    <= status_next;
            act_reg       <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        n_reg   <= n_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = rdv_reg;
    assign status        = status_reg;
    assign cursor_active = act_reg;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == S_IDLE)
        else $error("item accepted while a command is in progress");
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("head and tail disagree on an empty list");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= bump_reg)
        else $error("more freed nodes than nodes ever handed out");
    a_cursor_nil: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == NIL |-> cur_reg == NIL)
        else $error("cursor active on an empty list");
`endif

endmodule

// File: sv/doubly_linked_list_engine.sv
// State path from acceptance to the registered result item, per command:
// Idle only: clear, query, cursor jumps, overwrite, unused codes and commands with no target.
// Idle, look: reads, cursor moves, insert into a full store. Idle, unlink: delete at an end.
// Idle, look, link: insert. Idle, find, unlink: delete by the cursor; no neighbor ends it in find.
// The next item is accepted the cycle after a result is registered unless the output is stalled.
// Reset empties the list and deactivates the cursor; node memories need no clearing.
module doubly_linked_list_engine
    import dll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         command,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic               cursor_active
);

    dll_mem_req_t req;
    dll_mem_rsp_t rsp;

    dll_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .status        (status),
        .cursor_active (cursor_active),
        .mem_req       (req),
        .mem_rsp       (rsp)
    );

    dll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val (
        .clk   (clk),
        .we    (req.val_we),
        .waddr (req.val_waddr),
        .wdata (req.val_wdata),
        .raddr (req.val_raddr),
        .rdata (rsp.val)
    );

    dll_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_nxt (
        .clk   (clk),
        .we    (req.nxt_we),
        .waddr (req.nxt_waddr),
        .wdata (req.nxt_wdata),
        .raddr (req.nxt_raddr),
        .rdata (rsp.nxt)
    );

    dll_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prv (
        .clk   (clk),
        .we    (req.prv_we),
        .waddr (req.prv_waddr),
        .wdata (req.prv_wdata),
        .raddr (req.prv_raddr),
        .rdata (rsp.prv)
    );

    dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_fre (
        .clk   (clk),
        .we    (req.fre_we),
        .waddr (req.fre_waddr),
        .wdata (req.fre_wdata),
        .raddr (req.fre_raddr),
        .rdata (rsp.fre)
    );

endmodule
